/* hdl/lgs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CFG_W    = 11;
  localparam int POS_W    = 10;
  localparam int MIN_SIZE = 3;
  localparam int WIN_COLS = 2;

  typedef enum logic [0:0] {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_t;

  // 3x3 neighborhood, each column top/middle/bottom in bits 0/1/2
  typedef struct packed {
    logic [2:0] older;
    logic [2:0] newer;
    logic [2:0] cur;
  } win_t;

  typedef struct packed {
    logic             next_alive;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
  } out_beat_t;

  // Clamp a written size into range and return its last index
  function automatic logic [CFG_W-1:0] last_index(input logic [CFG_W-1:0] v,
                                                  input int unsigned max_n);
    logic [CFG_W-1:0] res;
    if (v < CFG_W'(MIN_SIZE)) begin
      res = CFG_W'(MIN_SIZE - 1);
    end else if (32'(v) > max_n) begin
      res = CFG_W'(max_n - 1);
    end else begin
      res = v - CFG_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/lgs_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lgs_in_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink (input valid, input cell_alive, output ready);
endinterface

`default_nettype wire

/* hdl/lgs_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lgs_out_if;
  import lgs_pkg::*;
  logic             valid;
  logic             ready;
  logic             next_alive;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             frame_last;

  modport source (output valid, output next_alive, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input next_alive, input out_row, input out_col,
                input frame_last, output ready);
endinterface

`default_nettype wire

/* hdl/lgs_line_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgs_line_store (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [lgs_pkg::COL_W-1:0] waddr,
  input  wire logic [1:0]                wdata,
  input  wire logic [lgs_pkg::COL_W-1:0] raddr,
  output logic [1:0]                     rdata
);
  import lgs_pkg::*;

  // bit 1: upper row, bit 0: lower row
  logic [1:0] mem [MAX_COLS];
  logic [1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/lgs_col_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgs_col_cell (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift_en,
  input  wire logic [2:0] col_in,
  output logic [2:0]      col_out
);

  logic [2:0] col_r;
  logic [2:0] col_nxt;

  assign col_nxt = shift_en ? col_in : col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 3'b000;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

`default_nettype wire

/* hdl/lgs_rule.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgs_rule (
  input  wire lgs_pkg::win_t win,
  input  wire logic          force_dead,
  output logic               next_alive
);
  import lgs_pkg::*;

  logic [3:0] n;
  logic       center;

  assign center = win.newer[1];

  // eight neighbors: all of the outer columns, top and bottom of the middle
  assign n = 4'(win.older[0]) + 4'(win.older[1]) + 4'(win.older[2])
           + 4'(win.newer[0]) + 4'(win.newer[2])
           + 4'(win.cur[0]) + 4'(win.cur[1]) + 4'(win.cur[2]);

  always_comb begin
    case (n)
      4'd3:    next_alive = 1'b1;
      4'd2:    next_alive = center;
      default: next_alive = 1'b0;
    endcase
    if (force_dead) begin
      next_alive = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hdl/life_generation_stencil_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Life (B3/S23) generation stencil. Cells of the current generation stream in
// raster order, one per beat; when cell (r,c) arrives with r,c >= 1 the next
// state of cell (r-1,c-1) leaves on the output channel with its row, column
// and a frame_last flag on the final cell of the grid. The outer ring is dead,
// and the last row and column are never emitted. One cell is taken per clock:
// the line store is read one column ahead so its single read port never
// stalls, and a two-beat output buffer keeps input flowing while one result
// waits. Throughput drops below one per clock only while both output slots are
// full. Writing either size register restarts the frame at row 0, column 0;
// sizes are clamped to 3..1024.
module life_generation_stencil_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  lgs_in_if.sink                         in_ch,
  lgs_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [lgs_pkg::CFG_W-1:0] cfg_data
);
  import lgs_pkg::*;

  logic [COL_W-1:0] cols_last_r, cols_last_nxt;
  logic [ROW_W-1:0] rows_last_r, rows_last_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_acc;
  logic             border;
  logic             bot;
  logic [1:0]       ls_rdata;
  logic [2:0]       chain [WIN_COLS+1];
  win_t             win;
  logic             emit;
  logic             rule_next;
  out_beat_t        beat_new;
  out_beat_t        ent0_r, ent0_nxt, ent1_r, ent1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;
  logic [CFG_W-1:0] cfg_last;

  assign in_acc = in_ch.valid && in_ch.ready;

  // configuration and position counters
  assign cfg_last = last_index(cfg_data, (cfg_index == CFG_COLS) ? MAX_COLS : MAX_ROWS);

  always_comb begin
    cols_last_nxt = cols_last_r;
    rows_last_nxt = rows_last_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COLS: cols_last_nxt = cfg_last[COL_W-1:0];
        CFG_ROWS: rows_last_nxt = cfg_last[ROW_W-1:0];
        default:  ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_r >= cols_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r >= rows_last_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_last_r <= COL_W'(MAX_COLS - 1);
      rows_last_r <= ROW_W'(MAX_ROWS - 1);
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      cols_last_r <= cols_last_nxt;
      rows_last_r <= rows_last_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
    end
  end

  assign border = (row_r == '0) || (row_r >= rows_last_r)
               || (col_r == '0) || (col_r >= cols_last_r);
  assign bot    = in_ch.cell_alive && !border;

  // read address follows the next column, so data for col_r is always ready
  lgs_line_store u_line_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_r),
    .wdata ({ls_rdata[0], bot}),
    .raddr (col_nxt),
    .rdata (ls_rdata)
  );

  assign chain[0] = {bot, ls_rdata[0], ls_rdata[1]};

  for (genvar g = 0; g < WIN_COLS; g++) begin : g_cells
    lgs_col_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_acc),
      .col_in   (chain[g]),
      .col_out  (chain[g+1])
    );
  end

  assign win.cur   = chain[0];
  assign win.newer = chain[1];
  assign win.older = chain[2];

  lgs_rule u_rule (
    .win        (win),
    .force_dead ((row_r == ROW_W'(1)) || (col_r == COL_W'(1))),
    .next_alive (rule_next)
  );

  assign emit = (row_r != '0) && (col_r != '0);

  always_comb begin
    beat_new.next_alive = rule_next;
    beat_new.out_row    = POS_W'(row_r - ROW_W'(1));
    beat_new.out_col    = POS_W'(col_r - COL_W'(1));
    beat_new.frame_last = (row_r >= rows_last_r) && (col_r >= cols_last_r);
  end

  // two-entry output buffer, entry 0 is the head
  assign push = in_acc && emit;
  assign pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    cnt_nxt  = cnt_r;
    if (pop) begin
      ent0_nxt = ent1_r;
    end
    if (push) begin
      if ((cnt_r == 2'd0) || (cnt_r == 2'd1 && pop)) begin
        ent0_nxt = beat_new;
      end else begin
        ent1_nxt = beat_new;
      end
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  assign in_ch.ready       = (cnt_r != 2'd2);
  assign out_ch.valid      = (cnt_r != 2'd0);
  assign out_ch.next_alive = ent0_r.next_alive;
  assign out_ch.out_row    = ent0_r.out_row;
  assign out_ch.out_col    = ent0_r.out_col;
  assign out_ch.frame_last = ent0_r.frame_last;

  a_col_bound : assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= cols_last_r)
    else $error("column counter past last column");

  a_row_bound : assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= rows_last_r)
    else $error("row counter past last row");

  a_push_held : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && !pop) |=> out_ch.valid)
    else $error("emitted result lost from output buffer");

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> (cnt_r == 2'd2))
    else $error("output buffer count changed while full and stalled");

endmodule

`default_nettype wire

/* test/life_next_state_checker.sv */
`timescale 1ns / 1ps

module life_next_state_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  lgs_in_if                         in_mon,
  lgs_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);
  import lgs_pkg::*;

  int unsigned       width_cells;
  int unsigned       height_cells;
  int unsigned       row_pos;
  int unsigned       col_pos;
  bit [MAX_COLS-1:0] upper_line;
  bit [MAX_COLS-1:0] lower_line;
  bit [2:0]          win_older;
  bit [2:0]          win_newer;
  out_beat_t         next_state_q[$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] raw,
                                            input int unsigned top);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > top) return top;
    return raw;
  endfunction

  function automatic void flag(input string what);
    if (mismatches < 10) $display("%0t ns: %s", $time, what);
    mismatches++;
  endfunction

  task automatic take_size(input cfg_idx_t which, input logic [CFG_W-1:0] raw);
    case (which)
      CFG_COLS: width_cells = clamp_dim(raw, MAX_COLS);
      CFG_ROWS: height_cells = clamp_dim(raw, MAX_ROWS);
      default: ;
    endcase
    // any size write restarts the frame
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic take_cell(input logic alive);
    bit          top_bit;
    bit          mid_bit;
    bit          low_bit;
    bit          centre;
    bit [2:0]    col_now;
    int unsigned live;
    out_beat_t   beat;
    low_bit = alive;
    if (row_pos == 0 || row_pos >= height_cells - 1 ||
        col_pos == 0 || col_pos >= width_cells - 1) begin
      low_bit = 1'b0;
    end
    top_bit = upper_line[col_pos];
    mid_bit = lower_line[col_pos];
    upper_line[col_pos] = mid_bit;
    lower_line[col_pos] = low_bit;
    col_now = {low_bit, mid_bit, top_bit};
    if (row_pos >= 1 && col_pos >= 1) begin
      centre = win_newer[1];
      live = $countones(win_older) + $countones(win_newer) + $countones(col_now) - centre;
      beat.next_alive = (live == 3) || (live == 2 && centre);
      // the dead ring stays dead
      if (row_pos == 1 || col_pos == 1) beat.next_alive = 1'b0;
      beat.out_row = POS_W'(row_pos - 1);
      beat.out_col = POS_W'(col_pos - 1);
      beat.frame_last = (row_pos >= height_cells - 1) && (col_pos >= width_cells - 1);
      next_state_q.push_back(beat);
    end
    win_older = win_newer;
    win_newer = col_now;
    if (col_pos >= width_cells - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= height_cells - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic check_beat();
    out_beat_t want;
    if (next_state_q.size() == 0) begin
      flag($sformatf("unexpected beat: row %0d col %0d alive %0b last %0b",
                     out_mon.out_row, out_mon.out_col, out_mon.next_alive,
                     out_mon.frame_last));
      return;
    end
    want = next_state_q.pop_front();
    if (out_mon.next_alive !== want.next_alive || out_mon.out_row !== want.out_row ||
        out_mon.out_col !== want.out_col || out_mon.frame_last !== want.frame_last) begin
      flag($sformatf({"cell mismatch: expected row %0d col %0d alive %0b last %0b, ",
                      "got row %0d col %0d alive %0b last %0b"},
                     want.out_row, want.out_col, want.next_alive, want.frame_last,
                     out_mon.out_row, out_mon.out_col, out_mon.next_alive,
                     out_mon.frame_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_cells = MAX_COLS;
      height_cells = MAX_ROWS;
      row_pos = 0;
      col_pos = 0;
      upper_line = '0;
      lower_line = '0;
      win_older = '0;
      win_newer = '0;
      next_state_q.delete();
    end else begin
      if (cfg_we) take_size(cfg_idx_t'(cfg_index), cfg_data);
      if (in_mon.valid && in_mon.ready) take_cell(in_mon.cell_alive);
      if (out_mon.valid && out_mon.ready) check_beat();
    end
    pending <= next_state_q.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import lgs_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_CELLS  = 420;
  localparam int EDGE_CELLS    = 96;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int MAX_WAIT      = 19;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fails;
  int               pending;
  int unsigned      quiet_cycles = 0;
  int unsigned      grid_cols = MAX_COLS;
  int unsigned      grid_rows = MAX_ROWS;
  int unsigned      random_cells = 0;
  bit               in_calm = 1'b0;
  bit               out_calm = 1'b0;

  lgs_in_if  in_if();
  lgs_out_if out_if();

  life_generation_stencil_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  life_next_state_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fails),
    .pending    (pending)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cell(input bit alive);
    int unsigned gap;
    if ($urandom_range(63, 0) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(MAX_WAIT, 0);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cell_alive <= alive;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_random_cells(input int unsigned count, input int unsigned density);
    repeat (count) send_cell($urandom_range(3, 0) < density);
  endtask

  // Write the chosen size registers back to back, then drop the enable once.
  task automatic set_grid(input bit wr_cols, input logic [CFG_W-1:0] cols_raw,
                          input bit wr_rows, input logic [CFG_W-1:0] rows_raw);
    if (wr_cols) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_COLS;
      cfg_data <= cols_raw;
      grid_cols = (cols_raw < MIN_SIZE) ? MIN_SIZE : (cols_raw > MAX_COLS) ? MAX_COLS : cols_raw;
      @(posedge clk);
    end
    if (wr_rows) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_ROWS;
      cfg_data <= rows_raw;
      grid_rows = (rows_raw < MIN_SIZE) ? MIN_SIZE : (rows_raw > MAX_ROWS) ? MAX_ROWS : rows_raw;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Hold the input, let every predicted beat leave, then let the pipeline empty.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase();
    logic [CFG_W-1:0] cols_raw;
    logic [CFG_W-1:0] rows_raw;
    int unsigned      which;
    int unsigned      cells;
    cols_raw = CFG_W'(($urandom_range(7, 0) == 0) ? $urandom_range(2, 0)
                                                  : $urandom_range(10, 3));
    rows_raw = CFG_W'(($urandom_range(7, 0) == 0) ? $urandom_range(2, 0)
                                                  : $urandom_range(10, 3));
    which = $urandom_range(3, 0);
    set_grid(which != 1, cols_raw, which != 0, rows_raw);
    // whole generations, sometimes plus part of another so the next write lands mid-frame
    cells = $urandom_range(2, 1) * grid_cols * grid_rows;
    if ($urandom_range(1, 0) == 1) cells += $urandom_range(grid_cols * grid_rows - 1, 0);
    send_random_cells(cells, $urandom_range(3, 1));
    random_cells += cells;
    drain();
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(63, 0) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(MAX_WAIT, 0);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (out_if.valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin : stimulus
    int r;
    int c;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.cell_alive <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_COLS;
    cfg_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Vertical blinker inside a live border: the border is taken as dead,
    // the ends die, the middle survives and two side cells are born.
    set_grid(1'b1, CFG_W'(5), 1'b1, CFG_W'(5));
    for (r = 0; r < 5; r++) begin
      for (c = 0; c < 5; c++) begin
        send_cell(r == 0 || r == 4 || c == 0 || c == 4 || c == 2);
      end
    end
    drain();

    while (random_cells < RANDOM_CELLS) run_phase();

    // Widest grid, requested above range, then tallest grid, a partial frame each.
    set_grid(1'b1, CFG_W'(2047), 1'b1, CFG_W'(MIN_SIZE));
    send_random_cells(EDGE_CELLS, 2);
    drain();
    set_grid(1'b1, CFG_W'(MIN_SIZE), 1'b1, CFG_W'(MAX_ROWS));
    send_random_cells(EDGE_CELLS, 2);
    drain();

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
